FILE: design/nearest_palette_color_macros.svh
// Assertion macros shared by the nearest palette colour RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef NEAREST_PALETTE_COLOR_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MACROS_SVH
`ifndef SYNTHESIS
// check that holds outside reset
`define NPC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("npc check failed");
// check that holds during reset as well
`define NPC_ASSERT_RST(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("npc reset check failed");
`else
`define NPC_ASSERT(name, clk, rst_n, prop)
`define NPC_ASSERT_RST(name, clk, prop)
`endif
`endif

FILE: design/npc_pkg.sv
// Package for the nearest palette colour block: word types, palette table, helpers.
// No dependencies; used by npc_dist, npc_argmin and nearest_palette_color.
package npc_pkg;

    // palette geometry
    localparam int PAL_ENTRIES  = 16;
    localparam int PALETTE_SIZE = 16;
    localparam int PAL_LIMIT    = (PALETTE_SIZE > PAL_ENTRIES) ? PAL_ENTRIES :
                                  ((PALETTE_SIZE < 1) ? 1 : PALETTE_SIZE);
    localparam int IDX_W        = $clog2(PAL_ENTRIES);
    localparam int COMP_W       = 8;
    localparam int SQ_W         = 2 * COMP_W;
    localparam int DIST_W       = SQ_W + 2;
    localparam int GROUP_SIZE   = 4;
    localparam int NUM_GROUPS   = PAL_ENTRIES / GROUP_SIZE;

    // largest real distance: three full-scale squares
    localparam logic [DIST_W-1:0] DIST_MAX    = DIST_W'(3 * 255 * 255);
    // entries beyond the active palette never win
    localparam logic [DIST_W-1:0] DIST_MASKED = '1;

    typedef logic [DIST_W-1:0] dist_t;

    typedef struct packed {
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [IDX_W-1:0]  color_index;
        logic [IDX_W+3:0]  attribute;
    } result_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        dist_t            distance;
    } cand_t;

    typedef logic  [PAL_ENTRIES-1:0][2:0][COMP_W-1:0] diff_vec_t;
    typedef logic  [PAL_ENTRIES-1:0][2:0][SQ_W-1:0]   sq_vec_t;
    typedef dist_t [PAL_ENTRIES-1:0]                dist_vec_t;
    typedef cand_t [NUM_GROUPS-1:0]                 group_vec_t;

    // fixed palette, one entry per index
    function automatic pixel_t pal_color(input logic [IDX_W-1:0] idx);
        pixel_t c;
        unique case (idx)
            4'd0:  c = '{blue: 8'd12,  green: 8'd12,  red: 8'd12};
            4'd1:  c = '{blue: 8'd218, green: 8'd55,  red: 8'd0};
            4'd2:  c = '{blue: 8'd15,  green: 8'd161, red: 8'd19};
            4'd3:  c = '{blue: 8'd218, green: 8'd151, red: 8'd58};
            4'd4:  c = '{blue: 8'd30,  green: 8'd15,  red: 8'd197};
            4'd5:  c = '{blue: 8'd151, green: 8'd22,  red: 8'd135};
            4'd6:  c = '{blue: 8'd0,   green: 8'd156, red: 8'd197};
            4'd7:  c = '{blue: 8'd204, green: 8'd204, red: 8'd204};
            4'd8:  c = '{blue: 8'd118, green: 8'd118, red: 8'd118};
            4'd9:  c = '{blue: 8'd255, green: 8'd120, red: 8'd58};
            4'd10: c = '{blue: 8'd12,  green: 8'd198, red: 8'd22};
            4'd11: c = '{blue: 8'd214, green: 8'd214, red: 8'd96};
            4'd12: c = '{blue: 8'd83,  green: 8'd72,  red: 8'd230};
            4'd13: c = '{blue: 8'd157, green: 8'd0,   red: 8'd180};
            4'd14: c = '{blue: 8'd168, green: 8'd241, red: 8'd249};
            4'd15: c = '{blue: 8'd242, green: 8'd242, red: 8'd242};
        endcase
        return c;
    endfunction

    // absolute difference of two components
    function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                  input logic [COMP_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // keep the earlier candidate unless the later one is strictly nearer
    function automatic cand_t pick(input cand_t lo, input cand_t hi);
        return (hi.distance < lo.distance) ? hi : lo;
    endfunction

endpackage

FILE: design/npc_dist.sv
// Distance stages: absolute differences, squares and per-entry sums for all entries.
// Depends on npc_pkg and nearest_palette_color_macros.svh.
`include "nearest_palette_color_macros.svh"

module npc_dist (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    output logic                pix_stall,
    input  npc_pkg::pixel_t     pix,
    output logic                dist_valid,
    input  logic                dist_stall,
    output npc_pkg::dist_vec_t  dists
);

    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                 s1_ready, s2_ready, s3_ready;
    npc_pkg::diff_vec_t   diff_reg, diff_next;
    npc_pkg::sq_vec_t     sq_reg, sq_next;
    npc_pkg::dist_vec_t   sum_reg, sum_next;

    // per-stage ready lets bubbles collapse
    assign s3_ready  = !s3_valid_reg || !dist_stall;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pix_stall = !s1_ready;

    // stage 1: component differences against every palette entry
    always_comb
    begin
        npc_pkg::pixel_t col;
        for (int i = 0; i < npc_pkg::PAL_ENTRIES; i++)
        begin
            col = npc_pkg::pal_color(npc_pkg::IDX_W'(i));
            diff_next[i][0] = npc_pkg::abs_diff(col.blue,  pix.blue);
            diff_next[i][1] = npc_pkg::abs_diff(col.green, pix.green);
            diff_next[i][2] = npc_pkg::abs_diff(col.red,   pix.red);
        end
    end

    // stage 2: squares
    always_comb
    begin
        for (int i = 0; i < npc_pkg::PAL_ENTRIES; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sq_next[i][c] = {{npc_pkg::COMP_W{1'b0}}, diff_reg[i][c]} *
                                {{npc_pkg::COMP_W{1'b0}}, diff_reg[i][c]};
            end
        end
    end

    // stage 3: distance sums, unused entries pushed out of reach
    always_comb
    begin
        for (int i = 0; i < npc_pkg::PAL_ENTRIES; i++)
        begin
            if (i < npc_pkg::PAL_LIMIT)
            begin
                sum_next[i] = npc_pkg::DIST_W'(sq_reg[i][0]) +
                              npc_pkg::DIST_W'(sq_reg[i][1]) +
                              npc_pkg::DIST_W'(sq_reg[i][2]);
            end
            else
            begin
                sum_next[i] = npc_pkg::DIST_MASKED;
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= pix_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s1_ready) diff_reg <= diff_next;
        if (s2_ready) sq_reg   <= sq_next;
        if (s3_ready) sum_reg  <= sum_next;
    end

    assign dist_valid = s3_valid_reg;
    assign dists      = sum_reg;

    // checks
    `NPC_ASSERT_RST(a_dist_reset_empty, clk,
        !rst_n |=> (!s1_valid_reg && !s2_valid_reg && !s3_valid_reg))
    `NPC_ASSERT(a_dist_entry0_bound, clk, rst_n,
        s3_valid_reg |-> (sum_reg[0] <= npc_pkg::DIST_MAX))
    `NPC_ASSERT(a_dist_hold_on_stall, clk, rst_n,
        (s3_valid_reg && dist_stall) |=> (s3_valid_reg && $stable(sum_reg)))

endmodule

FILE: design/npc_argmin.sv
// Registered minimum tree over the per-entry distances; forms the result word.
// Depends on npc_pkg and nearest_palette_color_macros.svh.
`include "nearest_palette_color_macros.svh"

module npc_argmin (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                dist_valid,
    output logic                dist_stall,
    input  npc_pkg::dist_vec_t  dists,
    output logic                result_valid,
    input  logic                result_stall,
    output npc_pkg::result_t    result
);

    logic                  s4_valid_reg, s5_valid_reg;
    logic                  s4_ready, s5_ready;
    npc_pkg::group_vec_t   grp_reg, grp_next;
    npc_pkg::cand_t        best_next;
    logic [npc_pkg::IDX_W-1:0] idx_reg;

    assign s5_ready   = !s5_valid_reg || !result_stall;
    assign s4_ready   = !s4_valid_reg || s5_ready;
    assign dist_stall = !s4_ready;

    // stage 4: two compare levels inside each group of four
    always_comb
    begin
        npc_pkg::cand_t c0, c1, c2, c3;
        for (int g = 0; g < npc_pkg::NUM_GROUPS; g++)
        begin
            c0 = '{idx: npc_pkg::IDX_W'(4 * g),     distance: dists[4 * g]};
            c1 = '{idx: npc_pkg::IDX_W'(4 * g + 1), distance: dists[4 * g + 1]};
            c2 = '{idx: npc_pkg::IDX_W'(4 * g + 2), distance: dists[4 * g + 2]};
            c3 = '{idx: npc_pkg::IDX_W'(4 * g + 3), distance: dists[4 * g + 3]};
            grp_next[g] = npc_pkg::pick(npc_pkg::pick(c0, c1), npc_pkg::pick(c2, c3));
        end
    end

    // stage 5: two compare levels across the group winners
    assign best_next = npc_pkg::pick(npc_pkg::pick(grp_reg[0], grp_reg[1]),
                                     npc_pkg::pick(grp_reg[2], grp_reg[3]));

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s4_ready) s4_valid_reg <= dist_valid;
            if (s5_ready) s5_valid_reg <= s4_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s4_ready) grp_reg <= grp_next;
        if (s5_ready) idx_reg <= best_next.idx;
    end

    // output word
    assign result_valid       = s5_valid_reg;
    assign result.color_index = idx_reg;
    assign result.attribute   = {idx_reg, 4'b0000};

    // checks
    `NPC_ASSERT_RST(a_min_reset_empty, clk,
        !rst_n |=> (!s4_valid_reg && !s5_valid_reg))
    `NPC_ASSERT(a_min_active_entry, clk, rst_n,
        s5_valid_reg |-> (idx_reg < npc_pkg::PAL_LIMIT))
    `NPC_ASSERT(a_min_is_minimum, clk, rst_n,
        s4_valid_reg |-> ((best_next.distance <= grp_reg[0].distance) &&
                          (best_next.distance <= grp_reg[1].distance) &&
                          (best_next.distance <= grp_reg[2].distance) &&
                          (best_next.distance <= grp_reg[3].distance)))
    `NPC_ASSERT(a_min_hold_on_stall, clk, rst_n,
        (s4_valid_reg && s5_valid_reg && result_stall) |=>
            (s4_valid_reg && $stable(grp_reg)))

endmodule

FILE: design/nearest_palette_color.sv
// Nearest palette colour: 24-bit pixel to the closest of 16 fixed colours.
// One result word per cycle sustained while result_stall is low.
// Five register stages: differences, squares, sums, group minimum, final minimum.
// Each stage holds its own valid bit, so bubbles close up under result_stall.
// rst_n (async, active low) empties the pipeline; payload registers are not reset.
// Depends on npc_pkg, npc_dist and npc_argmin.

module nearest_palette_color (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  npc_pkg::pixel_t   pixel,
    output logic              result_valid,
    input  logic              result_stall,
    output npc_pkg::result_t  result
);

    logic                dist_valid;
    logic                dist_stall;
    npc_pkg::dist_vec_t  dists;

    // distance stages
    npc_dist u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pixel_valid),
        .pix_stall  (pixel_stall),
        .pix        (pixel),
        .dist_valid (dist_valid),
        .dist_stall (dist_stall),
        .dists      (dists)
    );

    // minimum search and output register
    npc_argmin u_argmin (
        .clk          (clk),
        .rst_n        (rst_n),
        .dist_valid   (dist_valid),
        .dist_stall   (dist_stall),
        .dists        (dists),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

FILE: tb/tb.sv
// Self-checking bench for nearest_palette_color: directed rows, then random pixels.
// Each result word is checked against a typed expected index or an in-bench nearest-colour predictor.
// Depends on npc_pkg and the nearest_palette_color RTL only.

module tb;

    localparam int RANDOM_PIXELS = 1350;
    localparam int HOLD_CYCLES   = 64;
    localparam int TAIL_CYCLES   = 20;
    localparam int SHOW_LIMIT    = 10;
    localparam int DIRECTED_ROWS = 25;

    // directed row flags: expected index typed in, or left to the predictor
    localparam logic TYPED = 1'b1;
    localparam logic FREE  = 1'b0;

    // palette as blue, green, red bytes
    localparam logic [23:0] PALETTE_BGR [16] = '{
        {8'd12,  8'd12,  8'd12 },
        {8'd218, 8'd55,  8'd0  },
        {8'd15,  8'd161, 8'd19 },
        {8'd218, 8'd151, 8'd58 },
        {8'd30,  8'd15,  8'd197},
        {8'd151, 8'd22,  8'd135},
        {8'd0,   8'd156, 8'd197},
        {8'd204, 8'd204, 8'd204},
        {8'd118, 8'd118, 8'd118},
        {8'd255, 8'd120, 8'd58 },
        {8'd12,  8'd198, 8'd22 },
        {8'd214, 8'd214, 8'd96 },
        {8'd83,  8'd72,  8'd230},
        {8'd157, 8'd0,   8'd180},
        {8'd168, 8'd241, 8'd249},
        {8'd242, 8'd242, 8'd242}
    };

    // directed rows: {blue, green, red, typed flag, expected index}
    localparam logic [28:0] DIRECTED [DIRECTED_ROWS] = '{
        // exact palette colours land on their own entry
        {8'd12,  8'd12,  8'd12,  TYPED, 4'd0 },
        {8'd218, 8'd55,  8'd0,   TYPED, 4'd1 },
        {8'd15,  8'd161, 8'd19,  TYPED, 4'd2 },
        {8'd218, 8'd151, 8'd58,  TYPED, 4'd3 },
        {8'd30,  8'd15,  8'd197, TYPED, 4'd4 },
        {8'd151, 8'd22,  8'd135, TYPED, 4'd5 },
        {8'd0,   8'd156, 8'd197, TYPED, 4'd6 },
        {8'd204, 8'd204, 8'd204, TYPED, 4'd7 },
        {8'd118, 8'd118, 8'd118, TYPED, 4'd8 },
        {8'd255, 8'd120, 8'd58,  TYPED, 4'd9 },
        {8'd12,  8'd198, 8'd22,  TYPED, 4'd10},
        {8'd214, 8'd214, 8'd96,  TYPED, 4'd11},
        {8'd83,  8'd72,  8'd230, TYPED, 4'd12},
        {8'd157, 8'd0,   8'd180, TYPED, 4'd13},
        {8'd168, 8'd241, 8'd249, TYPED, 4'd14},
        {8'd242, 8'd242, 8'd242, TYPED, 4'd15},
        // black and white
        {8'd0,   8'd0,   8'd0,   TYPED, 4'd0 },
        {8'd255, 8'd255, 8'd255, TYPED, 4'd15},
        // greys exactly midway between two entries: lower index wins
        {8'd65,  8'd65,  8'd65,  TYPED, 4'd0 },
        {8'd161, 8'd161, 8'd161, TYPED, 4'd7 },
        {8'd223, 8'd223, 8'd223, TYPED, 4'd7 },
        // bit patterns and saturated primaries
        {8'hAA,  8'h55,  8'hFF,  FREE,  4'd0 },
        {8'h55,  8'hAA,  8'h00,  FREE,  4'd0 },
        {8'd255, 8'd0,   8'd0,   FREE,  4'd0 },
        {8'd0,   8'd255, 8'd255, FREE,  4'd0 }
    };

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              pixel_valid  = 1'b0;
    logic              pixel_stall;
    npc_pkg::pixel_t   pixel        = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    npc_pkg::result_t  result;

    npc_pkg::result_t  expected_q [$];
    npc_pkg::result_t  offer_want   = '0;
    int                idle_pct     = 0;
    int                stall_pct    = 0;
    int                hold_left    = 0;
    int                errors       = 0;
    int                pixels_in    = 0;
    int                results_out  = 0;

    nearest_palette_color i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // nearest entry by squared distance; only a strictly smaller one replaces the best
    function automatic npc_pkg::result_t nearest_entry(input npc_pkg::pixel_t px);
        int                limit;
        int                best;
        int                best_d;
        int                d;
        int                db;
        int                dg;
        int                dr;
        logic [23:0]       c;
        npc_pkg::result_t  r;
        limit  = (npc_pkg::PALETTE_SIZE > 16) ? 16 :
                 ((npc_pkg::PALETTE_SIZE < 1) ? 1 : npc_pkg::PALETTE_SIZE);
        best   = 0;
        best_d = 0;
        for (int i = 0; i < limit; i++)
        begin
            c  = PALETTE_BGR[i];
            db = int'(px.blue)  - int'(c[23:16]);
            dg = int'(px.green) - int'(c[15:8]);
            dr = int'(px.red)   - int'(c[7:0]);
            d  = db * db + dg * dg + dr * dr;
            if (i == 0 || d < best_d)
            begin
                best_d = d;
                best   = i;
            end
        end
        r.color_index = best[3:0];
        r.attribute   = {best[3:0], 4'b0000};
        return r;
    endfunction

    // base plus a random offset of up to span either way, clamped to a byte
    function automatic logic [7:0] jitter(input int base, input int span);
        int v;
        v = base + int'($urandom_range(2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    // half uniform, the rest near one entry or near the midpoint of two
    function automatic npc_pkg::pixel_t random_pixel();
        int               pick;
        logic [23:0]      ca;
        logic [23:0]      cb;
        npc_pkg::pixel_t  px;
        pick = $urandom_range(9);
        ca   = PALETTE_BGR[$urandom_range(15)];
        cb   = PALETTE_BGR[$urandom_range(15)];
        if (pick < 5)
            px = 24'($urandom);
        else if (pick < 8)
        begin
            px.blue  = jitter(int'(ca[23:16]), 6);
            px.green = jitter(int'(ca[15:8]), 6);
            px.red   = jitter(int'(ca[7:0]), 6);
        end
        else
        begin
            px.blue  = jitter((int'(ca[23:16]) + int'(cb[23:16])) / 2, 1);
            px.green = jitter((int'(ca[15:8]) + int'(cb[15:8])) / 2, 1);
            px.red   = jitter((int'(ca[7:0]) + int'(cb[7:0])) / 2, 1);
        end
        return px;
    endfunction

    task automatic log_error(input string what, input npc_pkg::result_t want,
                             input npc_pkg::result_t got);
        errors++;
        if (errors <= SHOW_LIMIT)
            $display("ERROR %0t: %s: expected index %0d attr 0x%02h, got index %0d attr 0x%02h",
                     $time, what, want.color_index, want.attribute,
                     got.color_index, got.attribute);
    endtask

    // offer one pixel word, with random idle cycles first; called and left at a falling edge
    task automatic send_pixel(input npc_pkg::pixel_t px, input npc_pkg::result_t want);
        while (int'($urandom_range(99)) < idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        offer_want  <= want;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering until every expected word has come back
    task automatic drain();
        pixel_valid <= 1'b0;
        @(negedge clk);
        while (expected_q.size() != 0)
            @(negedge clk);
    endtask

    // receiver: random stall, or a counted hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else
            result_stall <= (int'($urandom_range(99)) < stall_pct);
    end

    // accepted pixels queue their expectation; accepted results are checked in order
    always @(posedge clk)
    begin
        npc_pkg::result_t want;
        if (rst_n)
        begin
            if (pixel_valid && !pixel_stall)
            begin
                expected_q.push_back(offer_want);
                pixels_in++;
            end
            if (result_valid && !result_stall)
            begin
                results_out++;
                if (expected_q.size() == 0)
                    log_error("result word with nothing expected", '0, result);
                else
                begin
                    want = expected_q.pop_front();
                    if (result.color_index !== want.color_index)
                        log_error("color_index mismatch", want, result);
                    else if (result.attribute !== want.attribute)
                        log_error("attribute mismatch", want, result);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [28:0]       row;
        npc_pkg::pixel_t   px;
        npc_pkg::result_t  want;

        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows, no idling
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = DIRECTED[i];
            px  = row[28:5];
            if (row[4] == TYPED)
            begin
                want.color_index = row[3:0];
                want.attribute   = {row[3:0], 4'b0000};
            end
            else
                want = nearest_entry(px);
            send_pixel(px, want);
        end
        drain();

        // sender idles lightly, receiver stalls heavily
        idle_pct  = 16;
        stall_pct = 51;
        repeat (RANDOM_PIXELS / 3)
        begin
            px = random_pixel();
            send_pixel(px, nearest_entry(px));
        end
        drain();

        // the other way round
        idle_pct  = 51;
        stall_pct = 16;
        repeat (RANDOM_PIXELS / 3)
        begin
            px = random_pixel();
            send_pixel(px, nearest_entry(px));
        end
        drain();

        // full rate, opening with a long output hold so the pipeline backs up
        idle_pct  = 0;
        stall_pct = 0;
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        @(negedge clk);
        repeat (RANDOM_PIXELS - 2 * (RANDOM_PIXELS / 3))
        begin
            px = random_pixel();
            send_pixel(px, nearest_entry(px));
        end
        drain();

        repeat (TAIL_CYCLES)
            @(negedge clk);
        if (expected_q.size() != 0)
        begin
            errors += expected_q.size();
            $display("ERROR: %0d expected result words never arrived", expected_q.size());
        end

        $display("Summary: %0d pixels accepted, %0d results checked, %0d errors.",
                 pixels_in, results_out, errors);
        $display("Palette, extreme and tie rows, random pixels in three mixes, %0d-cycle hold.",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
